// ===== sv/sv7seg_pkg.sv =====
// shared types, constants and the seven-segment digit table for the signed value display block
// no dependencies
package sv7seg_pkg;

    localparam int VALUE_W = 32;
    localparam int ADDR_W  = 7;
    localparam int SEG_W   = 7;
    localparam int PLACES  = 4;
    localparam int MAG_W   = 14;
    localparam int DIGIT_W = 4;
    localparam int PROD_W  = 28;

    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS = 7'h40;

    localparam logic [MAG_W-1:0] SHOW_POS_LIMIT = 14'd9999;
    localparam logic [MAG_W-1:0] SHOW_NEG_LIMIT = 14'd999;

    // reciprocal multipliers, exact for values up to 9999
    localparam logic [PROD_W-1:0] DIV10_MUL     = 28'd6554;
    localparam int                DIV10_SHIFT   = 16;
    localparam logic [PROD_W-1:0] DIV100_MUL    = 28'd5243;
    localparam int                DIV100_SHIFT  = 19;
    localparam logic [PROD_W-1:0] DIV1000_MUL   = 28'd8389;
    localparam int                DIV1000_SHIFT = 23;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             over;
    } t_round;

    typedef logic [PLACES-1:0][SEG_W-1:0] t_places;

    function automatic logic [SEG_W-1:0] seg_of_digit(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0: code = 7'h3F;
            4'd1: code = 7'h06;
            4'd2: code = 7'h5B;
            4'd3: code = 7'h4F;
            4'd4: code = 7'h66;
            4'd5: code = 7'h6D;
            4'd6: code = 7'h7D;
            4'd7: code = 7'h07;
            4'd8: code = 7'h7F;
            4'd9: code = 7'h6F;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== sv/sv7seg_round.sv =====
// rounds a signed fixed-point value half away from zero and checks the display range
// depends on sv7seg_pkg
module sv7seg_round #(
    parameter int FRAC_BITS = 8
) (
    input  logic signed [sv7seg_pkg::VALUE_W-1:0] i_value,
    output sv7seg_pkg::t_round                     o_round
);

    localparam logic [sv7seg_pkg::VALUE_W+1:0] Half =
        ((sv7seg_pkg::VALUE_W+2)'(1) << FRAC_BITS) >> 1;

    logic                             neg_in;
    logic                             neg_out;
    logic [sv7seg_pkg::VALUE_W:0]     abs_val;
    logic [sv7seg_pkg::VALUE_W+1:0]   rounded;

    always_comb begin
        neg_in  = i_value[sv7seg_pkg::VALUE_W-1];
        abs_val = neg_in ? (33'h1_0000_0000 - {1'b0, i_value}) : {1'b0, i_value};
        rounded = ({1'b0, abs_val} + Half) >> FRAC_BITS;
        neg_out = neg_in && (rounded != '0);
        o_round.neg  = neg_out;
        o_round.over = neg_out
            ? (rounded > (sv7seg_pkg::VALUE_W+2)'(sv7seg_pkg::SHOW_NEG_LIMIT))
            : (rounded > (sv7seg_pkg::VALUE_W+2)'(sv7seg_pkg::SHOW_POS_LIMIT));
        o_round.mag  = rounded[sv7seg_pkg::MAG_W-1:0];
    end

endmodule

// ===== sv/sv7seg_format.sv =====
// splits the rounded magnitude into decimal digits and builds the four place codes
// depends on sv7seg_pkg
module sv7seg_format (
    input  sv7seg_pkg::t_round  i_round,
    output sv7seg_pkg::t_places o_places
);

    logic [sv7seg_pkg::PROD_W-1:0]  mag_w;
    logic [sv7seg_pkg::MAG_W-1:0]   q1;
    logic [sv7seg_pkg::MAG_W-1:0]   q2;
    logic [sv7seg_pkg::MAG_W-1:0]   q3;
    logic [sv7seg_pkg::DIGIT_W-1:0] d0;
    logic [sv7seg_pkg::DIGIT_W-1:0] d1;
    logic [sv7seg_pkg::DIGIT_W-1:0] d2;
    logic [sv7seg_pkg::DIGIT_W-1:0] d3;

    always_comb begin
        mag_w = sv7seg_pkg::PROD_W'(i_round.mag);
        q1 = sv7seg_pkg::MAG_W'((mag_w * sv7seg_pkg::DIV10_MUL) >> sv7seg_pkg::DIV10_SHIFT);
        q2 = sv7seg_pkg::MAG_W'((mag_w * sv7seg_pkg::DIV100_MUL) >> sv7seg_pkg::DIV100_SHIFT);
        q3 = sv7seg_pkg::MAG_W'((mag_w * sv7seg_pkg::DIV1000_MUL) >> sv7seg_pkg::DIV1000_SHIFT);
        d0 = sv7seg_pkg::DIGIT_W'(i_round.mag - sv7seg_pkg::MAG_W'(q1 * 14'd10));
        d1 = sv7seg_pkg::DIGIT_W'(q1 - sv7seg_pkg::MAG_W'(q2 * 14'd10));
        d2 = sv7seg_pkg::DIGIT_W'(q2 - sv7seg_pkg::MAG_W'(q3 * 14'd10));
        d3 = sv7seg_pkg::DIGIT_W'(q3);

        if (i_round.over) begin
            o_places = {sv7seg_pkg::PLACES{sv7seg_pkg::SEG_MINUS}};
        end else begin
            o_places[3] = sv7seg_pkg::seg_of_digit(d0);

            if (q1 != '0) begin
                o_places[2] = sv7seg_pkg::seg_of_digit(d1);
            end else if (i_round.neg) begin
                o_places[2] = sv7seg_pkg::SEG_MINUS;
            end else begin
                o_places[2] = sv7seg_pkg::SEG_BLANK;
            end

            if (q2 != '0) begin
                o_places[1] = sv7seg_pkg::seg_of_digit(d2);
            end else if (i_round.neg && q1 != '0) begin
                o_places[1] = sv7seg_pkg::SEG_MINUS;
            end else begin
                o_places[1] = sv7seg_pkg::SEG_BLANK;
            end

            if (q3 != '0) begin
                o_places[0] = sv7seg_pkg::seg_of_digit(d3);
            end else if (i_round.neg && q2 != '0) begin
                o_places[0] = sv7seg_pkg::SEG_MINUS;
            end else begin
                o_places[0] = sv7seg_pkg::SEG_BLANK;
            end
        end
    end

endmodule

// ===== sv/signed_value_to_seven_segment.sv =====
// top level: stream handshake, input register and result register around the formatter
// depends on sv7seg_pkg, sv7seg_round and sv7seg_format
//
// Converts one signed fixed-point beat per clock into four seven-segment codes. A beat is
// taken in every cycle while the output side keeps up; each accepted beat passes through
// the input register and then the result register. The path between the two registers is
// the 34-bit rounding add and the three parallel reciprocal multiplies that split the
// magnitude into decimal digits.
module signed_value_to_seven_segment #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // display_address[6:0], fixed_value[38:7], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // target_address[6:0], segments_first[13:7],
                                          // segments_second[20:14], segments_third[27:21],
                                          // segments_fourth[34:28], zero pad
    output logic        o_m_axis_tuser    // overrange
);

    logic                                   r_in_valid;
    logic [sv7seg_pkg::ADDR_W-1:0]          r_in_addr;
    logic signed [sv7seg_pkg::VALUE_W-1:0]  r_in_value;
    logic                                   r_out_valid;
    logic [sv7seg_pkg::ADDR_W-1:0]          r_out_addr;
    sv7seg_pkg::t_places                    r_out_places;
    logic                                   r_out_over;

    logic                out_free;
    logic                in_advance;
    logic                in_take;
    sv7seg_pkg::t_round  round_res;
    sv7seg_pkg::t_places places;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign in_advance      = r_in_valid && out_free;
    assign o_s_axis_tready = !r_in_valid || out_free;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    sv7seg_round #(
        .FRAC_BITS(FRAC_BITS)
    ) u_round (
        .i_value(r_in_value),
        .o_round(round_res)
    );

    sv7seg_format u_format (
        .i_round (round_res),
        .o_places(places)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
        if (in_take) begin
            r_in_addr  <= i_s_axis_tdata[6:0];
            r_in_value <= i_s_axis_tdata[38:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (in_advance) begin
            r_out_addr   <= r_in_addr;
            r_out_places <= places;
            r_out_over   <= round_res.over;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_over;
    assign o_m_axis_tdata  = {5'b0, r_out_places[3], r_out_places[2], r_out_places[1],
                              r_out_places[0], r_out_addr};

    // accepted beat always lands in the input register
    a_take_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> r_in_valid)
        else $error("accepted beat lost at input register");

    // overrange shows dashes in every place
    a_over_dashes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_over) |->
            (r_out_places == {sv7seg_pkg::PLACES{sv7seg_pkg::SEG_MINUS}}))
        else $error("overrange result without dashes");

    // in range the rightmost place always holds a digit
    a_units_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_over) |->
            (r_out_places[3] != sv7seg_pkg::SEG_BLANK &&
             r_out_places[3] != sv7seg_pkg::SEG_MINUS))
        else $error("rightmost place is not a digit");

    // a waiting result is not overwritten by the next beat
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |=> $stable(r_out_places) && $stable(r_out_addr))
        else $error("stalled result changed");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for signed_value_to_seven_segment: directed table then random beats
// with random gaps and stalls on both sides, results checked against typed rows or a model
// depends on sv7seg_pkg and the rtl of signed_value_to_seven_segment
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 8;
    localparam int RANDOM_BEATS = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam logic [32:0] ROUND_HALF = (33'd1 << FRAC_BITS) >> 1;
    localparam int SHOW_MAX = 9999;
    localparam int SHOW_MIN_MAG = 999;

    localparam logic [sv7seg_pkg::SEG_W-1:0] DIGIT_SEG [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
    };

    typedef struct packed {
        logic [sv7seg_pkg::ADDR_W-1:0] addr;
        logic [sv7seg_pkg::SEG_W-1:0]  first;
        logic [sv7seg_pkg::SEG_W-1:0]  second;
        logic [sv7seg_pkg::SEG_W-1:0]  third;
        logic [sv7seg_pkg::SEG_W-1:0]  fourth;
        logic                          over;
    } t_display;

    typedef struct packed {
        logic [sv7seg_pkg::ADDR_W-1:0]  addr;
        logic [sv7seg_pkg::VALUE_W-1:0] value;
        logic                           typed;
        t_display                       want;
    } t_stim_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_axis_tvalid;
    logic               o_s_axis_tready;
    logic [39:0]        i_s_axis_tdata;   // display_address[6:0], fixed_value[38:7], zero pad
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready;
    logic [39:0]        o_m_axis_tdata;   // target_address[6:0], segments_first[13:7],
                                          // segments_second[20:14], segments_third[27:21],
                                          // segments_fourth[34:28], zero pad
    logic               o_m_axis_tuser;   // overrange

    t_display  display_q[$];
    t_stim_row directed_rows[$];
    int        fail_count = 0;
    bit        send_quiet;
    bit        recv_quiet;

    signed_value_to_seven_segment #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic t_display predict_display(
        input logic [sv7seg_pkg::ADDR_W-1:0]  addr,
        input logic [sv7seg_pkg::VALUE_W-1:0] value);
        logic [32:0]                  mag;
        logic                         neg;
        logic                         over;
        int unsigned                  rest;
        int                           pos;
        logic [sv7seg_pkg::SEG_W-1:0] place [4];
        t_display                     r;
        neg = value[sv7seg_pkg::VALUE_W-1];
        mag = neg ? (33'h1_0000_0000 - {1'b0, value}) : {1'b0, value};
        mag = (mag + ROUND_HALF) >> FRAC_BITS;
        if (mag == 0) begin
            neg = 1'b0;
        end
        over = neg ? (mag > SHOW_MIN_MAG) : (mag > SHOW_MAX);
        for (int k = 0; k < 4; k++) begin
            place[k] = over ? sv7seg_pkg::SEG_MINUS : sv7seg_pkg::SEG_BLANK;
        end
        if (!over) begin
            rest = mag[31:0];
            pos = 3;
            do begin
                place[pos] = DIGIT_SEG[rest % 10];
                rest = rest / 10;
                pos--;
            end while (rest != 0 && pos >= 0);
            if (neg && pos >= 0) begin
                place[pos] = sv7seg_pkg::SEG_MINUS;
            end
        end
        r = '{addr, place[0], place[1], place[2], place[3], over};
        return r;
    endfunction

    function automatic t_display dashes(input logic [sv7seg_pkg::ADDR_W-1:0] addr);
        return '{addr, sv7seg_pkg::SEG_MINUS, sv7seg_pkg::SEG_MINUS, sv7seg_pkg::SEG_MINUS,
                 sv7seg_pkg::SEG_MINUS, 1'b1};
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [sv7seg_pkg::VALUE_W-1:0] random_value();
        int k;
        int frac;
        int bases [7] = '{-1000, -999, -1, 0, 1, 9999, 10000};
        int fracs [5];
        fracs = '{0, int'(ROUND_HALF) - 1, int'(ROUND_HALF), int'(ROUND_HALF) + 1,
                  (1 << FRAC_BITS) - 1};
        unique case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2, 3, 4, 5, 6: begin
                k = int'($urandom_range(0, 11100)) - 1100;
                frac = $urandom_range(0, (1 << FRAC_BITS) - 1);
                return k * (1 << FRAC_BITS) + frac;
            end
            7: begin
                k = bases[$urandom_range(0, 6)];
                frac = fracs[$urandom_range(0, 4)];
                if (k < 0) begin
                    return -((-k) * (1 << FRAC_BITS) + frac);
                end
                return k * (1 << FRAC_BITS) + frac;
            end
            8: return int'($urandom_range(0, 2047)) - 1024;
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    return 32'h8000_0000 + $urandom_range(0, 511);
                end
                return 32'h7FFF_FFFF - $urandom_range(0, 511);
            end
        endcase
    endfunction

    task automatic send_beat(input logic [sv7seg_pkg::ADDR_W-1:0] addr,
                             input logic [sv7seg_pkg::VALUE_W-1:0] value,
                             input t_display want, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, value, addr};
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        display_q.push_back(want);
    endtask

    task automatic check_field(input string name, input logic [sv7seg_pkg::SEG_W-1:0] want,
                               input logic [sv7seg_pkg::SEG_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_display want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (display_q.size() == 0) begin
                $error("result beat with nothing expected: tdata %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                want = display_q.pop_front();
                check_field("target_address", want.addr, o_m_axis_tdata[6:0]);
                check_field("segments_first", want.first, o_m_axis_tdata[13:7]);
                check_field("segments_second", want.second, o_m_axis_tdata[20:14]);
                check_field("segments_third", want.third, o_m_axis_tdata[27:21]);
                check_field("segments_fourth", want.fourth, o_m_axis_tdata[34:28]);
                check_field("overrange", {6'd0, want.over}, {6'd0, o_m_axis_tuser});
                if (o_m_axis_tdata[39:35] !== 5'd0) begin
                    $error("tdata pad: expected %h, actual %h", 5'd0, o_m_axis_tdata[39:35]);
                    fail_count++;
                end
            end
        end
    end

    // output side back-pressure
    initial begin
        int stall;
        stall = 0;
        recv_quiet      = 1'b0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 299) == 0) begin
                recv_quiet = ~recv_quiet;
            end
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                stall--;
            end else begin
                i_m_axis_tready <= 1'b1;
                stall = pick_gap(recv_quiet);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("signed_value_to_seven_segment regression: fail");
        $finish;
    end

    initial begin
        logic [sv7seg_pkg::ADDR_W-1:0]  addr;
        logic [sv7seg_pkg::VALUE_W-1:0] value;
        t_stim_row                      row;
        t_display                       want;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        send_quiet      = 1'b0;

        // typed rows: zero, extremes, overrange, all nines
        directed_rows.push_back('{7'd0, 32'h0000_0000, 1'b1,
            '{7'd0, sv7seg_pkg::SEG_BLANK, sv7seg_pkg::SEG_BLANK, sv7seg_pkg::SEG_BLANK,
              DIGIT_SEG[0], 1'b0}});
        directed_rows.push_back('{7'd127, 32'h7FFF_FFFF, 1'b1, dashes(7'd127)});
        directed_rows.push_back('{7'd85, 32'h8000_0000, 1'b1, dashes(7'd85)});
        directed_rows.push_back('{7'd42, 32'd9999 << FRAC_BITS, 1'b1,
            '{7'd42, DIGIT_SEG[9], DIGIT_SEG[9], DIGIT_SEG[9], DIGIT_SEG[9], 1'b0}});
        directed_rows.push_back('{7'd1, -(32'd999 << FRAC_BITS), 1'b1,
            '{7'd1, sv7seg_pkg::SEG_MINUS, DIGIT_SEG[9], DIGIT_SEG[9], DIGIT_SEG[9], 1'b0}});
        directed_rows.push_back('{7'd2, 32'd10000 << FRAC_BITS, 1'b1, dashes(7'd2)});
        directed_rows.push_back('{7'd3, -(32'd1000 << FRAC_BITS), 1'b1, dashes(7'd3)});
        directed_rows.push_back('{7'd64, 32'hFFFF_FFFF, 1'b1,
            '{7'd64, sv7seg_pkg::SEG_BLANK, sv7seg_pkg::SEG_BLANK, sv7seg_pkg::SEG_BLANK,
              DIGIT_SEG[0], 1'b0}});
        // halves, near halves and the rounding edges of the range
        directed_rows.push_back('{7'd5, 32'(ROUND_HALF), 1'b0, '0});
        directed_rows.push_back('{7'd6, -32'(ROUND_HALF), 1'b0, '0});
        directed_rows.push_back('{7'd7, 32'(ROUND_HALF) - 1, 1'b0, '0});
        directed_rows.push_back('{7'd8, -(32'(ROUND_HALF) - 1), 1'b0, '0});
        directed_rows.push_back('{7'd9, (32'd9999 << FRAC_BITS) + 32'(ROUND_HALF), 1'b0, '0});
        directed_rows.push_back('{7'd10, (32'd9999 << FRAC_BITS) + 32'(ROUND_HALF) - 1,
            1'b0, '0});
        directed_rows.push_back('{7'd11, -((32'd999 << FRAC_BITS) + 32'(ROUND_HALF)),
            1'b0, '0});
        directed_rows.push_back('{7'd12, -((32'd999 << FRAC_BITS) + 32'(ROUND_HALF) - 1),
            1'b0, '0});
        directed_rows.push_back('{7'd13, -(32'd2 << FRAC_BITS) - 32'(ROUND_HALF), 1'b0, '0});
        // assorted digit counts and signs
        directed_rows.push_back('{7'd20, 32'd5 << FRAC_BITS, 1'b0, '0});
        directed_rows.push_back('{7'd21, 32'd42 << FRAC_BITS, 1'b0, '0});
        directed_rows.push_back('{7'd22, 32'd1234 << FRAC_BITS, 1'b0, '0});
        directed_rows.push_back('{7'd23, -(32'd7 << FRAC_BITS), 1'b0, '0});
        directed_rows.push_back('{7'd24, -(32'd56 << FRAC_BITS), 1'b0, '0});
        directed_rows.push_back('{7'd25, 32'd8067 << FRAC_BITS, 1'b0, '0});
        directed_rows.push_back('{7'd126, 32'h5555_5555, 1'b0, '0});

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            want = row.typed ? row.want : predict_display(row.addr, row.value);
            send_beat(row.addr, row.value, want, pick_gap(1'b0));
        end

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n % 200 == 0) begin
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            addr  = 7'($urandom_range(0, 127));
            value = random_value();
            send_beat(addr, value, predict_display(addr, value), pick_gap(send_quiet));
        end

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (display_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && display_q.size() == 0) begin
            $display("signed_value_to_seven_segment regression: pass");
        end else begin
            $display("signed_value_to_seven_segment regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/sv7seg_pkg.sv
sv/sv7seg_round.sv
sv/sv7seg_format.sv
sv/signed_value_to_seven_segment.sv
tb/tb_top.sv
